// ===== src/conv3_pkg.sv =====
// Shared constants, types and helpers for the 3x3 convolution core.
// No dependencies; imported by every other file of the block.
package conv3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int KROW_W     = 12;
  localparam int PIX_W      = 8;
  localparam int COEF_W     = 4;
  localparam int COORD_W    = 10;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KERNEL_ROW0  = 3'd2;
  localparam logic [2:0] REG_KERNEL_ROW1  = 3'd3;
  localparam logic [2:0] REG_KERNEL_ROW2  = 3'd4;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(300);
  localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(300);
  localparam logic [KROW_W-1:0] KROW0_RST  = KROW_W'(16);
  localparam logic [KROW_W-1:0] KROW1_RST  = KROW_W'(449);
  localparam logic [KROW_W-1:0] KROW2_RST  = KROW_W'(16);

  typedef logic [2:0][PIX_W-1:0]  pix_col_t;
  typedef logic [2:0][COEF_W-1:0] coef_col_t;

  typedef struct packed {
    logic [PIX_W-1:0]   edge_value;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic full;
    logic push;
  } fifo_ctl_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] res;
    res = v;
    if (v < SIZE_W'(3)) res = SIZE_W'(3);
    else if (v > maxv)  res = maxv;
    return res;
  endfunction

endpackage

// ===== src/conv3_if.sv =====
// Handshake channel interfaces for the pixel input and the result output.
// Depends on conv3_pkg.
interface conv3_pix_if import conv3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface conv3_res_if import conv3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   edge_value;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               last_result;
  modport source (output valid, output edge_value, output out_row, output out_col,
                  output last_result, input ready);
  modport sink   (input valid, input edge_value, input out_row, input out_col,
                  input last_result, output ready);
endinterface

// ===== src/image_convolution_3x3_core.sv =====
// 3x3 convolution core over a raster pixel stream, with APB-style registers.
// Each result word passes stages s1, s2 and s3 and then the result queue before it is offered.
// Throughput: one pixel per cycle while the result queue is not full; a two-word result queue absorbs stalls.
// Reset (synchronous, rst_n low): counters and queue clear, registers take
// 300x300 and the Laplacian kernel; line stores are not cleared.
// Depends on conv3_pkg, conv3_if, conv3_line_buf, conv3_cell, conv3_out_fifo.
module image_convolution_3x3_core import conv3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  conv3_pix_if.sink          in_chan,
  conv3_res_if.source        out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [SIZE_W-1:0] width_r, height_r;
  logic [KROW_W-1:0] krow0_r, krow1_r, krow2_r;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  logic [COL_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]  row_cnt_r, row_cnt_nxt;

  logic              adv, acc;
  logic              fifo_full;
  fifo_ctl_t         fifo_ctl;
  result_t           res_word;

  logic              s1_v_r, s1_prod_r, s1_last_r;
  logic [PIX_W-1:0]  s1_px_r;
  logic [COL_W-1:0]  s1_addr_r;
  logic [COORD_W-1:0] s1_row_r, s1_col_r;
  logic              s2_v_r, s2_last_r;
  logic [COORD_W-1:0] s2_row_r, s2_col_r;
  logic              s3_v_r, s3_last_r;
  logic [COORD_W-1:0] s3_row_r, s3_col_r;

  logic [PIX_W-1:0]  lb_top, lb_mid;
  pix_col_t          col_chain [4];
  logic [PIX_W-1:0]  part [3];
  coef_col_t         coef [3];

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign w_eff   = clamp_size(width_r, SIZE_W'(MAX_WIDTH));
  assign h_eff   = clamp_size(height_r, SIZE_W'(MAX_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      krow0_r  <= KROW0_RST;
      krow1_r  <= KROW1_RST;
      krow2_r  <= KROW2_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
        REG_KERNEL_ROW0:  krow0_r  <= pwdata[KROW_W-1:0];
        REG_KERNEL_ROW1:  krow1_r  <= pwdata[KROW_W-1:0];
        REG_KERNEL_ROW2:  krow2_r  <= pwdata[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = DATA_W'(width_r);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(height_r);
      REG_KERNEL_ROW0:  prdata = DATA_W'(krow0_r);
      REG_KERNEL_ROW1:  prdata = DATA_W'(krow1_r);
      REG_KERNEL_ROW2:  prdata = DATA_W'(krow2_r);
      default:          prdata = '0;
    endcase
  end

  // Raster position of the next pixel
  assign adv              = !fifo_full;
  assign in_chan.ready    = adv;
  assign acc              = in_chan.valid && adv;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (acc) begin
      if ((SIZE_W'(col_cnt_r) + SIZE_W'(1)) >= w_eff) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = ((SIZE_W'(row_cnt_r) + SIZE_W'(1)) >= h_eff) ? '0
                                                                   : row_cnt_r + 1'b1;
      end else begin
        col_cnt_nxt = col_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (cfg_wr && (cfg_idx == REG_IMAGE_WIDTH || cfg_idx == REG_IMAGE_HEIGHT)) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r && s1_prod_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r   <= in_chan.pixel;
      s1_addr_r <= col_cnt_r;
      s1_prod_r <= (row_cnt_r >= ROW_W'(2)) && (col_cnt_r >= COL_W'(2));
      s1_row_r  <= COORD_W'(row_cnt_r - ROW_W'(2));
      s1_col_r  <= COORD_W'(col_cnt_r - COL_W'(2));
      s1_last_r <= (SIZE_W'(row_cnt_r) == h_eff - SIZE_W'(1)) &&
                   (SIZE_W'(col_cnt_r) == w_eff - SIZE_W'(1));
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
      s2_last_r <= s1_last_r;
      s3_row_r  <= s2_row_r;
      s3_col_r  <= s2_col_r;
      s3_last_r <= s2_last_r;
    end
  end

  conv3_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (col_cnt_r),
    .wr_en   (adv && s1_v_r),
    .wr_addr (s1_addr_r),
    .wr_top  (lb_mid),
    .wr_mid  (s1_px_r),
    .rd_top  (lb_top),
    .rd_mid  (lb_mid)
  );

  // Newest column enters cell 2 and moves toward cell 0
  assign col_chain[3] = {s1_px_r, lb_mid, lb_top};

  for (genvar y = 0; y < 3; y++) begin : g_cell
    assign coef[y] = {krow2_r[4*y +: COEF_W], krow1_r[4*y +: COEF_W], krow0_r[4*y +: COEF_W]};

    conv3_cell u_cell (
      .clk      (clk),
      .shift_en (adv && s1_v_r),
      .calc_en  (adv),
      .col_in   (col_chain[y+1]),
      .coef     (coef[y]),
      .col_out  (col_chain[y]),
      .part_out (part[y])
    );
  end

  assign res_word.edge_value  = part[0] + part[1] + part[2];
  assign res_word.out_row     = s3_row_r;
  assign res_word.out_col     = s3_col_r;
  assign res_word.last_result = s3_last_r;
  assign fifo_ctl.push        = adv && s3_v_r;
  assign fifo_ctl.full        = fifo_full;

  conv3_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (fifo_ctl),
    .word_in  (res_word),
    .full     (fifo_full),
    .out_chan (out_chan)
  );

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    SIZE_W'(col_cnt_r) < w_eff)
    else $error("column counter beyond image width");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    SIZE_W'(row_cnt_r) < h_eff)
    else $error("row counter beyond image height");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && s3_v_r) |=> s3_v_r)
    else $error("pending result dropped during stall");

endmodule

// ===== src/conv3_line_buf.sv =====
// Two line stores holding the two image rows above the current one.
// Registered read, one write per store per cycle. Depends on conv3_pkg.
module conv3_line_buf import conv3_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  logic [PIX_W-1:0] wr_top,
  input  logic [PIX_W-1:0] wr_mid,
  output logic [PIX_W-1:0] rd_top,
  output logic [PIX_W-1:0] rd_mid
);

  logic [PIX_W-1:0] store_a [MAX_WIDTH];
  logic [PIX_W-1:0] store_b [MAX_WIDTH];
  logic [PIX_W-1:0] rd_top_r;
  logic [PIX_W-1:0] rd_mid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_a[wr_addr] <= wr_top;
      store_b[wr_addr] <= wr_mid;
    end
    if (rd_en) begin
      rd_top_r <= store_a[rd_addr];
      rd_mid_r <= store_b[rd_addr];
    end
  end

  assign rd_top = rd_top_r;
  assign rd_mid = rd_mid_r;

endmodule

// ===== src/conv3_cell.sv =====
// One window column cell: holds three stacked pixels, passes them on to
// the older neighbor and forms its weighted column sum. Depends on conv3_pkg.
module conv3_cell import conv3_pkg::*; (
  input  logic             clk,
  input  logic             shift_en,
  input  logic             calc_en,
  input  pix_col_t         col_in,
  input  coef_col_t        coef,
  output pix_col_t         col_out,
  output logic [PIX_W-1:0] part_out
);

  pix_col_t                pix_r;
  logic [PIX_W-1:0]        part_r;
  logic signed [12:0]      prod [3];
  logic [PIX_W-1:0]        part_nxt;

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      prod[x] = $signed({1'b0, pix_r[x]}) * $signed(coef[x]);
    end
    part_nxt = prod[0][PIX_W-1:0] + prod[1][PIX_W-1:0] + prod[2][PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      pix_r <= col_in;
    end
    if (calc_en) begin
      part_r <= part_nxt;
    end
  end

  assign col_out  = pix_r;
  assign part_out = part_r;

endmodule

// ===== src/conv3_out_fifo.sv =====
// Two-word result queue decoupling the pipeline from the result channel.
// Depends on conv3_pkg and conv3_if.
module conv3_out_fifo import conv3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  fifo_ctl_t          ctl_in,
  input  result_t            word_in,
  output logic               full,
  conv3_res_if.source        out_chan
);

  result_t     mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic        pop;
  result_t     head;

  assign pop  = out_chan.valid && out_chan.ready;
  assign full = (cnt_r == 2'd2);

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl_in.push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (!ctl_in.push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (ctl_in.push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)         rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.push) begin
      mem_r[wr_ptr_r] <= word_in;
    end
  end

  assign head                 = mem_r[rd_ptr_r];
  assign out_chan.valid       = (cnt_r != 2'd0);
  assign out_chan.edge_value  = head.edge_value;
  assign out_chan.out_row     = head.out_row;
  assign out_chan.out_col     = head.out_col;
  assign out_chan.last_result = head.last_result;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl_in.push && ctl_in.full && !pop))
    else $error("result word pushed into full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== dv/conv3_edge_checker.sv =====
// Scoreboard for the 3x3 convolution core: tracks register writes and pixel words,
// predicts each result word and checks it and every register readback.
// Depends on conv3_pkg and the channel interfaces in conv3_if.
module conv3_edge_checker import conv3_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  conv3_pix_if              pix,
  conv3_res_if              res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  output int                failures,
  output int                outstanding
);

  logic [PIX_W-1:0]  upper_line  [MAX_WIDTH];
  logic [PIX_W-1:0]  middle_line [MAX_WIDTH];
  logic [PIX_W-1:0]  window [9];
  int                next_row;
  int                next_col;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [KROW_W-1:0] kernel_reg [3];
  result_t           edge_queue [$];

  function automatic int fit_size(input logic [SIZE_W-1:0] v, input int cap);
    if (v < 3) return 3;
    if (v > cap) return cap;
    return int'(v);
  endfunction

  function automatic logic [DATA_W-1:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_IMAGE_WIDTH:  return DATA_W'(width_reg);
      REG_IMAGE_HEIGHT: return DATA_W'(height_reg);
      REG_KERNEL_ROW0:  return DATA_W'(kernel_reg[0]);
      REG_KERNEL_ROW1:  return DATA_W'(kernel_reg[1]);
      REG_KERNEL_ROW2:  return DATA_W'(kernel_reg[2]);
      default:          return '0;
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = data[SIZE_W-1:0];
        next_row  = 0;
        next_col  = 0;
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = data[SIZE_W-1:0];
        next_row   = 0;
        next_col   = 0;
      end
      REG_KERNEL_ROW0: kernel_reg[0] = data[KROW_W-1:0];
      REG_KERNEL_ROW1: kernel_reg[1] = data[KROW_W-1:0];
      REG_KERNEL_ROW2: kernel_reg[2] = data[KROW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic report(input string what, input longint want, input longint got);
    $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
    failures++;
  endtask

  task automatic convolve_pixel(input logic [PIX_W-1:0] px);
    int      w;
    int      h;
    int      r;
    int      c;
    int      acc;
    int      coef;
    result_t word;
    w = fit_size(width_reg, MAX_WIDTH);
    h = fit_size(height_reg, MAX_HEIGHT);
    c = (next_col >= w) ? w - 1 : next_col;
    r = (next_row >= h) ? h - 1 : next_row;
    for (int x = 0; x < 3; x++) begin
      window[3*x]   = window[3*x+1];
      window[3*x+1] = window[3*x+2];
    end
    window[2] = upper_line[c];
    window[5] = middle_line[c];
    window[8] = px;
    upper_line[c]  = middle_line[c];
    middle_line[c] = px;
    if (r >= 2 && c >= 2) begin
      acc = 0;
      for (int x = 0; x < 3; x++) begin
        for (int y = 0; y < 3; y++) begin
          coef = $signed(kernel_reg[x][4*y +: COEF_W]);
          acc += coef * int'(window[3*x+y]);
        end
      end
      word.edge_value  = acc[PIX_W-1:0];
      word.out_row     = COORD_W'(r - 2);
      word.out_col     = COORD_W'(c - 2);
      word.last_result = (r == h - 1) && (c == w - 1);
      edge_queue.push_back(word);
    end
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
      next_row = r;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      width_reg     = WIDTH_RST;
      height_reg    = HEIGHT_RST;
      kernel_reg[0] = KROW0_RST;
      kernel_reg[1] = KROW1_RST;
      kernel_reg[2] = KROW2_RST;
      next_row      = 0;
      next_col      = 0;
      foreach (window[i]) window[i] = '0;
      edge_queue.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) write_reg(paddr[ADDR_W-1:2], pwdata);
        else if (prdata !== reg_value(paddr[ADDR_W-1:2]))
          report("register readback", reg_value(paddr[ADDR_W-1:2]), prdata);
      end
      if (pix.valid && pix.ready) convolve_pixel(pix.pixel);
      if (res.valid && res.ready) begin
        if (edge_queue.size() == 0) begin
          $display("%0t unexpected result word: expected none, got value %0d row %0d col %0d last %0b",
                   $time, res.edge_value, res.out_row, res.out_col, res.last_result);
          failures++;
        end else begin
          want = edge_queue.pop_front();
          if (want.edge_value !== res.edge_value)
            report("edge_value", want.edge_value, res.edge_value);
          if (want.out_row !== res.out_row) report("out_row", want.out_row, res.out_row);
          if (want.out_col !== res.out_col) report("out_col", want.out_col, res.out_col);
          if (want.last_result !== res.last_result)
            report("last_result", want.last_result, res.last_result);
        end
      end
    end
    outstanding <= edge_queue.size();
  end

endmodule

// ===== dv/tb_image_convolution_3x3_core.sv =====
// Testbench top for image_convolution_3x3_core: resets the core, programs its
// registers and streams pixel words with random idling and a long output stall.
// Depends on conv3_pkg, conv3_if, the core and conv3_edge_checker.
module tb_image_convolution_3x3_core;
  import conv3_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              steady;
  int                hold_req;
  int                failures;
  int                outstanding;
  int                random_sent;

  conv3_pix_if pix_ch();
  conv3_res_if res_ch();

  image_convolution_3x3_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pix_ch),
    .out_chan (res_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  conv3_edge_checker edge_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix         (pix_ch),
    .res         (res_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("image_convolution_3x3_core verification failed");
    $finish;
  end

  // hold off the result channel on request, else idle at random
  initial begin
    int served;
    served = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != served) begin
        served++;
        res_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        res_ch.ready <= steady || ($urandom_range(0, 99) >= 29);
      end
    end
  end

  task automatic reg_access(input logic [2:0] idx, input logic wr,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_all();
    reg_access(REG_IMAGE_WIDTH, 1'b0, '0);
    reg_access(REG_IMAGE_HEIGHT, 1'b0, '0);
    reg_access(REG_KERNEL_ROW0, 1'b0, '0);
    reg_access(REG_KERNEL_ROW1, 1'b0, '0);
    reg_access(REG_KERNEL_ROW2, 1'b0, '0);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    while (!steady && $urandom_range(0, 99) < 29) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= p;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_run(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00);
      else send_pixel(PIX_W'($urandom));
    end
    random_sent += n;
  endtask

  // drop valid, wait for all results, then let in-flight pixels retire
  task automatic settle();
    pix_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic int pick_size();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2);
    return $urandom_range(3, 12);
  endfunction

  initial begin
    logic [DATA_W-1:0] data;
    int                n;
    int                w;
    int                h;
    int                cur_w;
    int                cur_h;
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel <= '0;
    steady       <= 1'b0;
    hold_req     <= 0;
    random_sent  = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    read_all();

    reg_access(REG_IMAGE_WIDTH, 1'b1, 32'd3);
    reg_access(REG_IMAGE_HEIGHT, 1'b1, 32'd3);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'hFF : 8'h00);
    settle();
    reg_access(REG_KERNEL_ROW0, 1'b1, 32'h888);
    reg_access(REG_KERNEL_ROW1, 1'b1, 32'h888);
    reg_access(REG_KERNEL_ROW2, 1'b1, 32'h888);
    repeat (9) send_pixel(8'hFF);
    settle();
    reg_access(REG_KERNEL_ROW0, 1'b1, 32'h777);
    reg_access(REG_KERNEL_ROW1, 1'b1, 32'h777);
    reg_access(REG_KERNEL_ROW2, 1'b1, 32'h777);
    for (int i = 0; i < 9; i++) send_pixel(i[0] ? 8'hFF : 8'h00);
    settle();

    reg_access(REG_IMAGE_WIDTH, 1'b1, 32'd8);
    reg_access(REG_IMAGE_HEIGHT, 1'b1, 32'd8);
    cur_w = 8;
    cur_h = 8;
    steady   <= 1'b1;
    hold_req <= hold_req + 1;
    send_run(200);
    settle();

    while (random_sent < 1050) begin
      steady <= ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) != 0) begin
        w = pick_size();
        data = $urandom;
        data[SIZE_W-1:0] = SIZE_W'(w);
        reg_access(REG_IMAGE_WIDTH, 1'b1, data);
        cur_w = (w < 3) ? 3 : w;
      end
      if ($urandom_range(0, 3) != 0) begin
        h = pick_size();
        data = $urandom;
        data[SIZE_W-1:0] = SIZE_W'(h);
        reg_access(REG_IMAGE_HEIGHT, 1'b1, data);
        cur_h = (h < 3) ? 3 : h;
      end
      if ($urandom_range(0, 1)) reg_access(REG_KERNEL_ROW0, 1'b1, $urandom);
      if ($urandom_range(0, 1)) reg_access(REG_KERNEL_ROW1, 1'b1, $urandom);
      if ($urandom_range(0, 1)) reg_access(REG_KERNEL_ROW2, 1'b1, $urandom);
      if ($urandom_range(0, 7) == 0) read_all();
      if ($urandom_range(0, 1)) n = cur_w * cur_h;
      else n = $urandom_range(1, 3 * cur_w * cur_h / 2);
      send_run(n);
      settle();
    end

    steady <= 1'b1;
    reg_access(REG_KERNEL_ROW1, 1'b1, $urandom);
    reg_access(REG_IMAGE_WIDTH, 1'b1, 32'd2);
    reg_access(REG_IMAGE_HEIGHT, 1'b1, 32'd2047);
    send_run(60);
    settle();
    reg_access(REG_IMAGE_WIDTH, 1'b1, 32'd2047);
    reg_access(REG_IMAGE_HEIGHT, 1'b1, 32'd1);
    send_run(40);
    settle();
    steady <= 1'b0;
    reg_access(REG_IMAGE_WIDTH, 1'b1, DATA_W'(MAX_WIDTH));
    reg_access(REG_IMAGE_HEIGHT, 1'b1, DATA_W'(MAX_HEIGHT));
    read_all();
    settle();

    if (failures == 0) begin
      $display("image_convolution_3x3_core verification clean");
    end else begin
      $display("image_convolution_3x3_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/conv3_pkg.sv
src/conv3_if.sv
src/conv3_line_buf.sv
src/conv3_cell.sv
src/conv3_out_fifo.sv
src/image_convolution_3x3_core.sv
dv/conv3_edge_checker.sv
dv/tb_image_convolution_3x3_core.sv
